// ===== rtl/core/tpqm_pkg.sv =====
// shared types and constants for the touch press qualifier and mapper
// used by tpqm_div, tpqm_checker and touch_press_qualifier_mapper, no dependencies
package tpqm_pkg;

	// field widths
	localparam int RAW_W   = 12;
	localparam int TIME_W  = 32;
	localparam int ORI_W   = 3;
	localparam int SCR_X_W = 8;
	localparam int SCR_Y_W = 9;

	// divider operand widths: |raw - lo| * top and |hi - lo|
	localparam int NUM_W = 2 * RAW_W;
	localparam int DEN_W = RAW_W;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESSURE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_X_HI     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_LO     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_HI     = 3'd5;

	// register reset values
	localparam logic [ORI_W-1:0] RST_ORIENTATION  = 3'd0;
	localparam logic [RAW_W-1:0] RST_MIN_PRESSURE = 12'd200;
	localparam logic [RAW_W-1:0] RST_RAW_LO       = 12'd200;
	localparam logic [RAW_W-1:0] RST_RAW_HI       = 12'd3900;

	// orientation bits
	localparam int ORI_SWAP = 0;
	localparam int ORI_MIRX = 1;
	localparam int ORI_MIRY = 2;

	// default parameters
	localparam int DEF_SCREEN_WIDTH  = 240;
	localparam int DEF_SCREEN_HEIGHT = 320;
	localparam int DEF_DEBOUNCE_MS   = 220;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/core/touch_press_qualifier_mapper.sv =====
// touch press qualifier and linear screen mapper, top level
// depends on tpqm_pkg and tpqm_div
//
// usage:
//   s_* takes one controller poll per request: tuser is the touched flag,
//   tdata carries sample_x, sample_y, sample_pressure and now_ms.
//   a poll that is not a new, debounced press with enough pressure is
//   absorbed in its accept cycle and yields nothing.
//   an accepted press runs both axis mappings through one shared serial
//   divider: per axis a multiply step, a start step, the serial quotient
//   bits and a step to pick up the quotient, then a step to load the output
//   register, and s_tready stays low until the result has been loaded.
//   throughput: one rejected poll per cycle while idle; a press is taken
//   only once the previous result has been loaded into the output register.
//   m_* holds the result until taken; a new poll is accepted while it waits,
//   and a further press waits in its last step until the register is free.
//   cfg_* writes one register per request, always ready; write only while idle.
//   reset clears the press-held flag, the last press time and restores the
//   register defaults; no clearing pass is needed.
module touch_press_qualifier_mapper
	import tpqm_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int DEBOUNCE_MS   = DEF_DEBOUNCE_MS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// sample_x[11:0], sample_y[23:12], sample_pressure[35:24], now_ms[67:36]
	input  logic [71:0]          s_tdata,
	// touched[0]
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// swapped_raw_x[11:0], swapped_raw_y[23:12], press_pressure[35:24],
	// screen_x[43:36], screen_y[52:44]
	output logic [55:0]          m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RAW_W-1:0]     cfg_data
);

	localparam logic [RAW_W-1:0]  TOP_X = RAW_W'(SCREEN_WIDTH - 1);
	localparam logic [RAW_W-1:0]  TOP_Y = RAW_W'(SCREEN_HEIGHT - 1);
	localparam logic [TIME_W-1:0] DEB   = TIME_W'(DEBOUNCE_MS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]        state_q;
	logic              axis_q;
	logic              held_q;
	logic [TIME_W-1:0] last_ms_q;
	logic              out_valid_q;
	logic [55:0]       out_data_q;

	logic [ORI_W-1:0]  ori_q;
	logic [RAW_W-1:0]  min_pr_q;
	logic [RAW_W-1:0]  x_lo_q;
	logic [RAW_W-1:0]  x_hi_q;
	logic [RAW_W-1:0]  y_lo_q;
	logic [RAW_W-1:0]  y_hi_q;

	logic [RAW_W-1:0]  rx_q;
	logic [RAW_W-1:0]  ry_q;
	logic [RAW_W-1:0]  pr_q;
	logic [RAW_W-1:0]  scr_x_q;
	logic [RAW_W-1:0]  scr_y_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic              zero_q;

	logic [RAW_W-1:0]  in_x;
	logic [RAW_W-1:0]  in_y;
	logic [RAW_W-1:0]  in_pr;
	logic [TIME_W-1:0] in_now;
	logic              in_acc;
	logic              pressed;
	logic [TIME_W-1:0] since;
	logic              take;

	logic [RAW_W-1:0]  a_raw;
	logic [RAW_W-1:0]  a_lo;
	logic [RAW_W-1:0]  a_hi;
	logic [RAW_W-1:0]  a_top;
	logic              a_mir;
	logic [RAW_W:0]    a_diff;
	logic [RAW_W:0]    a_span;
	logic [RAW_W-1:0]  diff_mag;
	logic [RAW_W-1:0]  span_mag;
	logic [RAW_W-1:0]  a_clamp;
	logic [RAW_W-1:0]  a_res;
	logic              out_free;
	logic              out_load;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign in_x   = s_tdata[11:0];
	assign in_y   = s_tdata[23:12];
	assign in_pr  = s_tdata[35:24];
	assign in_now = s_tdata[67:36];

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign pressed   = s_tuser && (in_pr >= min_pr_q);
	assign since     = in_now - last_ms_q;
	assign take      = pressed && !held_q && (since >= DEB);
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == S_OUT) && out_free;

	// per-axis operands for the shared multiply and divide
	always_comb begin
		a_raw = axis_q ? ry_q   : rx_q;
		a_lo  = axis_q ? y_lo_q : x_lo_q;
		a_hi  = axis_q ? y_hi_q : x_hi_q;
		a_top = axis_q ? TOP_Y  : TOP_X;
		a_mir = axis_q ? ori_q[ORI_MIRY] : ori_q[ORI_MIRX];
	end

	assign a_diff   = {1'b0, a_raw} - {1'b0, a_lo};
	assign a_span   = {1'b0, a_hi} - {1'b0, a_lo};
	assign diff_mag = a_diff[RAW_W] ? RAW_W'(-a_diff) : a_diff[RAW_W-1:0];
	assign span_mag = a_span[RAW_W] ? RAW_W'(-a_span) : a_span[RAW_W-1:0];

	// a negative quotient truncates to zero or below and clamps to zero
	assign a_clamp = zero_q ? '0 :
		(div_rsp.quot > {{(NUM_W-RAW_W){1'b0}}, a_top}) ? a_top : div_rsp.quot[RAW_W-1:0];
	assign a_res   = a_mir ? (a_top - a_clamp) : a_clamp;

	assign div_req.start = (state_q == S_START);
	assign div_req.num   = num_q;
	assign div_req.den   = den_q;

	tpqm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ori_q    <= RST_ORIENTATION;
			min_pr_q <= RST_MIN_PRESSURE;
			x_lo_q   <= RST_RAW_LO;
			x_hi_q   <= RST_RAW_HI;
			y_lo_q   <= RST_RAW_LO;
			y_hi_q   <= RST_RAW_HI;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIENTATION:  ori_q    <= cfg_data[ORI_W-1:0];
				REG_MIN_PRESSURE: min_pr_q <= cfg_data;
				REG_RAW_X_LO:     x_lo_q   <= cfg_data;
				REG_RAW_X_HI:     x_hi_q   <= cfg_data;
				REG_RAW_Y_LO:     y_lo_q   <= cfg_data;
				REG_RAW_Y_HI:     y_hi_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			held_q      <= 1'b0;
			last_ms_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!pressed) begin
							held_q <= 1'b0;
						end else if (take) begin
							held_q    <= 1'b1;
							last_ms_q <= in_now;
							axis_q    <= 1'b0;
							state_q   <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (axis_q) begin
							state_q <= S_OUT;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && take) begin
			rx_q <= ori_q[ORI_SWAP] ? in_y : in_x;
			ry_q <= ori_q[ORI_SWAP] ? in_x : in_y;
			pr_q <= in_pr;
		end
		if (state_q == S_MUL) begin
			num_q  <= NUM_W'({{(NUM_W-RAW_W){1'b0}}, diff_mag} *
				{{(NUM_W-RAW_W){1'b0}}, a_top});
			den_q  <= span_mag;
			zero_q <= (a_span == '0) || (a_diff == '0) || (a_diff[RAW_W] != a_span[RAW_W]);
		end
		if ((state_q == S_WAIT) && div_rsp.done) begin
			if (axis_q) begin
				scr_y_q <= a_res;
			end else begin
				scr_x_q <= a_res;
			end
		end
		if (out_load) begin
			out_data_q <= {3'b000, scr_y_q[SCR_Y_W-1:0], scr_x_q[SCR_X_W-1:0],
				pr_q, ry_q, rx_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/core/tpqm_div.sv =====
// serial restoring divider, one quotient bit per cycle, unsigned operands
// depends on tpqm_pkg for operand widths and request/response structs
module tpqm_div
	import tpqm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== rtl/core/tpqm_checker.sv =====
// port-level checker for touch_press_qualifier_mapper, bound to the top level
// depends on tpqm_pkg for the default screen size
module tpqm_checker
	import tpqm_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an untouched poll is absorbed at once
	a_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> s_tready)
		else $error("untouched poll stalled the input");

	// a result is only loaded after the mapping sequence, never from idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a mapping pass");

	// screen coordinates stay on the screen
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((SCREEN_WIDTH > 256) || (int'(m_tdata[43:36]) <= SCREEN_WIDTH - 1)) &&
			((SCREEN_HEIGHT > 512) || (int'(m_tdata[52:44]) <= SCREEN_HEIGHT - 1)))
		else $error("screen coordinate out of range");

endmodule

bind touch_press_qualifier_mapper tpqm_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tpqm_checker (.*);
